// ===== hdl/plpa_pkg.sv =====
// Shared widths, constants and the multiply-accumulate control type for the polygon measure block.
`timescale 1ns / 1ps

package plpa_pkg;

  // Field widths
  localparam int COORD_W    = 20;
  localparam int SCALE_W    = 24;
  localparam int OUT_W      = 48;
  localparam int STATUS_W   = 2;
  localparam int CMD_W      = 2;
  localparam int MODE_W     = 2;

  // Configuration port
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;

  // Segment squared length and its root
  localparam int ROOT_W     = COORD_W + 1;
  localparam int SQ_W       = 2 * ROOT_W;

  // Shared multiplier operands and wide-operand chunking
  localparam int MUL_A_W    = 33;
  localparam int MUL_B_W    = 25;
  localparam int CHUNK_W    = 32;
  localparam int MAC_K_W    = 2;

  localparam int MAX_POINTS_DEF = 256;
  localparam logic [SCALE_W-1:0] SCALE_RESET = 24'h010000;

  // One operation for the shared multiply-accumulate unit
  typedef struct packed {
    logic               en;
    logic               clr;
    logic               sub;
    logic [MAC_K_W-1:0] k;
    logic [MUL_A_W-1:0] a;
    logic [MUL_B_W-1:0] b;
  } mac_op_t;

endpackage

// ===== hdl/plpa_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module plpa_ram #(
  parameter int DATA_W = 20,
  parameter int DEPTH  = 256,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/plpa_mac.sv =====
// Shared signed multiply-accumulate unit: registered product, then shifted add into the accumulator.
`timescale 1ns / 1ps

module plpa_mac #(
  parameter int ACC_W = 99
) (
  input  logic              clk,
  input  logic              rst_n,
  input  plpa_pkg::mac_op_t op,
  output logic [ACC_W-1:0]  acc
);

  localparam int PROD_W = plpa_pkg::MUL_A_W + plpa_pkg::MUL_B_W;

  logic signed [PROD_W-1:0]   prod_r;
  logic signed [PROD_W-1:0]   prod_nxt;
  logic                       en_d_r;
  logic                       clr_d_r;
  logic                       sub_d_r;
  logic [plpa_pkg::MAC_K_W-1:0] k_d_r;
  logic [ACC_W-1:0]           acc_r;
  logic [ACC_W-1:0]           acc_nxt;
  logic [ACC_W-1:0]           addend;
  logic [ACC_W-1:0]           base;

  // Multiply stage
  assign prod_nxt = $signed(op.a) * $signed(op.b);

  // Accumulate stage: place the product at its chunk offset
  always_comb begin
    addend = ACC_W'(prod_r) << (k_d_r * plpa_pkg::CHUNK_W);
    base   = clr_d_r ? '0 : acc_r;
    if (sub_d_r) begin
      acc_nxt = base - addend;
    end else begin
      acc_nxt = base + addend;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_d_r <= 1'b0;
    end else begin
      en_d_r <= op.en;
    end
    prod_r  <= prod_nxt;
    clr_d_r <= op.clr;
    sub_d_r <= op.sub;
    k_d_r   <= op.k;
    if (en_d_r) begin
      acc_r <= acc_nxt;
    end
  end

  assign acc = acc_r;

endmodule

// ===== hdl/plpa_isqrt.sv =====
// Bit-serial integer square root: one root bit per cycle.
`timescale 1ns / 1ps

module plpa_isqrt (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [plpa_pkg::SQ_W-1:0]   value,
  output logic                        busy,
  output logic [plpa_pkg::ROOT_W-1:0] root
);

  localparam int SQ_W = plpa_pkg::SQ_W;

  logic            busy_r;
  logic            busy_nxt;
  logic [SQ_W-1:0] rem_r;
  logic [SQ_W-1:0] rem_nxt;
  logic [SQ_W-1:0] res_r;
  logic [SQ_W-1:0] res_nxt;
  logic [SQ_W-1:0] bit_r;
  logic [SQ_W-1:0] bit_nxt;
  logic [SQ_W-1:0] trial;

  // Load on start, then test one pair of bits per cycle
  always_comb begin
    busy_nxt = busy_r;
    rem_nxt  = rem_r;
    res_nxt  = res_r;
    bit_nxt  = bit_r;
    trial    = res_r + bit_r;
    if (start) begin
      busy_nxt = 1'b1;
      rem_nxt  = value;
      res_nxt  = '0;
      bit_nxt  = SQ_W'(1) << (SQ_W - 2);
    end else if (busy_r) begin
      if (rem_r >= trial) begin
        rem_nxt = rem_r - trial;
        res_nxt = (res_r >> 1) + bit_r;
      end else begin
        res_nxt = res_r >> 1;
      end
      bit_nxt = bit_r >> 2;
      if (bit_r[0]) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
    rem_r <= rem_nxt;
    res_r <= res_nxt;
    bit_r <= bit_nxt;
  end

  assign busy = busy_r;
  assign root = res_r[plpa_pkg::ROOT_W-1:0];

endmodule

// ===== hdl/polyline_length_polygon_area_top.sv =====
// Polygon vertex stack with running polyline length and shoelace area, one shared multiplier.
// When a segment is added or removed, the square root unit dominates the time from accept to result.
// Throughput: one transaction at a time; input stalls from accept until the result is registered.
// The result register lets the next transaction start while a result waits to be taken.
// Reset (synchronous, rst_n low): no vertices, sums zero, mode none, scale 1.0; RAM not cleared.
`timescale 1ns / 1ps

module polyline_length_polygon_area_top #(
  parameter int MAX_POINTS = plpa_pkg::MAX_POINTS_DEF,
  localparam int CNT_W = $clog2(MAX_POINTS + 1)
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // Input channel
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [plpa_pkg::CMD_W-1:0]            in_command,
  input  logic signed [plpa_pkg::COORD_W-1:0]   in_point_x,
  input  logic signed [plpa_pkg::COORD_W-1:0]   in_point_y,
  // Result channel
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [plpa_pkg::STATUS_W-1:0]         out_status,
  output logic [CNT_W-1:0]                      out_vertex_count,
  output logic [plpa_pkg::OUT_W-1:0]            out_path_length,
  output logic [plpa_pkg::OUT_W-1:0]            out_polygon_area,
  // Configuration port
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [plpa_pkg::APB_ADDR_W-1:0]       paddr,
  input  logic [plpa_pkg::APB_DATA_W-1:0]       pwdata,
  output logic [plpa_pkg::APB_DATA_W-1:0]       prdata,
  output logic                                  pready
);

  localparam int COORD_W    = plpa_pkg::COORD_W;
  localparam int SCALE_W    = plpa_pkg::SCALE_W;
  localparam int OUT_W      = plpa_pkg::OUT_W;
  localparam int CHUNK_W    = plpa_pkg::CHUNK_W;
  localparam int MAC_K_W    = plpa_pkg::MAC_K_W;
  localparam int MUL_A_W    = plpa_pkg::MUL_A_W;
  localparam int MUL_B_W    = plpa_pkg::MUL_B_W;
  localparam int AW         = $clog2(MAX_POINTS);
  localparam int LEN_W      = plpa_pkg::ROOT_W + CNT_W + 1;
  localparam int CROSS_W    = 2 * COORD_W + 1 + CNT_W;
  localparam int MAG_W      = CROSS_W;
  localparam int P1_W       = MAG_W + SCALE_W;
  localparam int ACC_W      = P1_W + SCALE_W + 1;
  localparam int NL         = (LEN_W + CHUNK_W - 1) / CHUNK_W;
  localparam int N1         = (MAG_W + CHUNK_W - 1) / CHUNK_W;
  localparam int N2         = (P1_W + CHUNK_W - 1) / CHUNK_W;
  localparam int OPND_W     = N2 * CHUNK_W;
  localparam int PLEN_SHIFT = 16;
  localparam int AREA_SHIFT = 2 * PLEN_SHIFT + 1;
  localparam int PLEN_TOP   = PLEN_SHIFT + OUT_W;
  localparam int AREA_TOP   = AREA_SHIFT + OUT_W;
  localparam int REG_SEL_BIT = 2;

  localparam logic [plpa_pkg::CMD_W-1:0] CMD_ADD    = 2'd0;
  localparam logic [plpa_pkg::CMD_W-1:0] CMD_REMOVE = 2'd1;
  localparam logic [plpa_pkg::CMD_W-1:0] CMD_CLEAR  = 2'd2;

  localparam logic [plpa_pkg::STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [plpa_pkg::STATUS_W-1:0] ST_NO_MODE = 2'd1;
  localparam logic [plpa_pkg::STATUS_W-1:0] ST_FULL    = 2'd2;
  localparam logic [plpa_pkg::STATUS_W-1:0] ST_EMPTY   = 2'd3;

  localparam logic [plpa_pkg::MODE_W-1:0] MODE_NONE = 2'd0;
  localparam logic REG_MODE = 1'b0;

  typedef enum logic [4:0] {
    S_IDLE, S_RD_A, S_RD_B, S_CAP_B,
    S_SQ_X, S_SQ_Y, S_SQ_W,
    S_XP_0, S_XP_1, S_XP_W, S_XP_ACC, S_ROOT,
    S_FIN, S_AREA,
    S_CL_0, S_CL_1, S_CL_W, S_CL_ACC,
    S_MS, S_MS_W, S_MS_ACC,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    MS_LEN, MS_AREA1, MS_AREA2
  } ms_step_t;

  state_t                        state_r, state_nxt;
  ms_step_t                      step_r, step_nxt;
  logic [plpa_pkg::MODE_W-1:0]   mode_r, mode_nxt;
  logic [SCALE_W-1:0]            scale_r, scale_nxt;
  logic [CNT_W-1:0]              count_r, count_nxt;
  logic [LEN_W-1:0]              len_sum_r, len_sum_nxt;
  logic [CROSS_W-1:0]            cross_r, cross_nxt;
  logic                          close_r, close_nxt;
  logic                          seg_sub_r, seg_sub_nxt;
  logic [AW-1:0]                 addr_a_r, addr_a_nxt;
  logic [AW-1:0]                 addr_b_r, addr_b_nxt;
  logic signed [COORD_W-1:0]     xa_r, xa_nxt, ya_r, ya_nxt;
  logic signed [COORD_W-1:0]     xb_r, xb_nxt, yb_r, yb_nxt;
  logic [OPND_W-1:0]             opnd_r, opnd_nxt;
  logic [MAC_K_W-1:0]            k_r, k_nxt;
  logic [MAC_K_W-1:0]            nch_r, nch_nxt;
  logic [plpa_pkg::STATUS_W-1:0] status_r, status_nxt;
  logic [OUT_W-1:0]              plen_r, plen_nxt;
  logic [OUT_W-1:0]              area_r, area_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [plpa_pkg::STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [CNT_W-1:0]              out_count_r, out_count_nxt;
  logic [OUT_W-1:0]              out_plen_r, out_plen_nxt;
  logic [OUT_W-1:0]              out_area_r, out_area_nxt;

  logic                          in_accept;
  logic                          cfg_write;
  logic                          ram_we;
  logic [AW-1:0]                 ram_raddr;
  logic [COORD_W-1:0]            rdata_x;
  logic [COORD_W-1:0]            rdata_y;
  logic signed [COORD_W:0]       dx;
  logic signed [COORD_W:0]       dy;
  logic [CROSS_W-1:0]            sum_s;
  logic [MAG_W-1:0]              mag;
  logic [ACC_W-1:0]              acc;
  plpa_pkg::mac_op_t             mac_op;
  logic                          sqrt_start;
  logic                          sqrt_busy;
  logic [plpa_pkg::ROOT_W-1:0]   sqrt_root;

  assign in_accept = in_valid && !in_stall;
  assign cfg_write = psel && penable && pwrite;

  // Store the new vertex on the accepting edge of an add that fits
  assign ram_we = in_accept && (in_command == CMD_ADD) && (mode_r != MODE_NONE) &&
                  (count_r != CNT_W'(MAX_POINTS));
  assign ram_raddr = (state_r == S_RD_A) ? addr_a_r : addr_b_r;

  plpa_ram #(
    .DATA_W (COORD_W),
    .DEPTH  (MAX_POINTS)
  ) u_ram_x (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count_r[AW-1:0]),
    .wdata (in_point_x),
    .raddr (ram_raddr),
    .rdata (rdata_x)
  );

  plpa_ram #(
    .DATA_W (COORD_W),
    .DEPTH  (MAX_POINTS)
  ) u_ram_y (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count_r[AW-1:0]),
    .wdata (in_point_y),
    .raddr (ram_raddr),
    .rdata (rdata_y)
  );

  plpa_mac #(
    .ACC_W (ACC_W)
  ) u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .op    (mac_op),
    .acc   (acc)
  );

  plpa_isqrt u_isqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sqrt_start),
    .value (acc[plpa_pkg::SQ_W-1:0]),
    .busy  (sqrt_busy),
    .root  (sqrt_root)
  );

  // Segment deltas and closed-polygon sum magnitude
  assign dx    = COORD_W'(1) == 0 ? '0 : (COORD_W + 1)'(xb_r) - (COORD_W + 1)'(xa_r);
  assign dy    = (COORD_W + 1)'(yb_r) - (COORD_W + 1)'(ya_r);
  assign sum_s = cross_r + acc[CROSS_W-1:0];
  assign mag   = sum_s[CROSS_W-1] ? (MAG_W'(0) - sum_s) : sum_s;

  // Sequencer
  always_comb begin
    state_nxt      = state_r;
    step_nxt       = step_r;
    mode_nxt       = mode_r;
    scale_nxt      = scale_r;
    count_nxt      = count_r;
    len_sum_nxt    = len_sum_r;
    cross_nxt      = cross_r;
    close_nxt      = close_r;
    seg_sub_nxt    = seg_sub_r;
    addr_a_nxt     = addr_a_r;
    addr_b_nxt     = addr_b_r;
    xa_nxt         = xa_r;
    ya_nxt         = ya_r;
    xb_nxt         = xb_r;
    yb_nxt         = yb_r;
    opnd_nxt       = opnd_r;
    k_nxt          = k_r;
    nch_nxt        = nch_r;
    status_nxt     = status_r;
    plen_nxt       = plen_r;
    area_nxt       = area_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_count_nxt  = out_count_r;
    out_plen_nxt   = out_plen_r;
    out_area_nxt   = out_area_r;
    mac_op         = '0;
    sqrt_start     = 1'b0;

    // Drop the result once taken
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          status_nxt = ST_OK;
          close_nxt  = 1'b0;
          state_nxt  = S_FIN;
          case (in_command)
            CMD_ADD: begin
              if (mode_r == MODE_NONE) begin
                status_nxt = ST_NO_MODE;
              end else if (count_r == CNT_W'(MAX_POINTS)) begin
                status_nxt = ST_FULL;
              end else begin
                count_nxt   = count_r + CNT_W'(1);
                seg_sub_nxt = 1'b0;
                addr_a_nxt  = AW'(count_r - CNT_W'(1));
                addr_b_nxt  = count_r[AW-1:0];
                if (count_r != '0) begin
                  state_nxt = S_RD_A;
                end
              end
            end
            CMD_REMOVE: begin
              if (count_r == '0) begin
                status_nxt = ST_EMPTY;
              end else begin
                count_nxt   = count_r - CNT_W'(1);
                seg_sub_nxt = 1'b1;
                addr_a_nxt  = AW'(count_r - CNT_W'(2));
                addr_b_nxt  = AW'(count_r - CNT_W'(1));
                if (count_r >= CNT_W'(2)) begin
                  state_nxt = S_RD_A;
                end
              end
            end
            CMD_CLEAR: begin
              count_nxt   = '0;
              len_sum_nxt = '0;
              cross_nxt   = '0;
            end
            default: begin
            end
          endcase
        end
      end

      // Fetch the vertex pair: A then B, through the registered RAM read port
      S_RD_A: begin
        state_nxt = S_RD_B;
      end
      S_RD_B: begin
        xa_nxt    = $signed(rdata_x);
        ya_nxt    = $signed(rdata_y);
        state_nxt = S_CAP_B;
      end
      S_CAP_B: begin
        xb_nxt    = $signed(rdata_x);
        yb_nxt    = $signed(rdata_y);
        state_nxt = close_r ? S_CL_0 : S_SQ_X;
      end

      // Squared segment length
      S_SQ_X: begin
        mac_op.en  = 1'b1;
        mac_op.clr = 1'b1;
        mac_op.a   = MUL_A_W'(dx);
        mac_op.b   = MUL_B_W'(dx);
        state_nxt  = S_SQ_Y;
      end
      S_SQ_Y: begin
        mac_op.en = 1'b1;
        mac_op.a  = MUL_A_W'(dy);
        mac_op.b  = MUL_B_W'(dy);
        state_nxt = S_SQ_W;
      end
      S_SQ_W: begin
        state_nxt = S_XP_0;
      end

      // Start the root alongside the segment cross term
      S_XP_0: begin
        sqrt_start = 1'b1;
        mac_op.en  = 1'b1;
        mac_op.clr = 1'b1;
        mac_op.a   = MUL_A_W'(xa_r);
        mac_op.b   = MUL_B_W'(yb_r);
        state_nxt  = S_XP_1;
      end
      S_XP_1: begin
        mac_op.en  = 1'b1;
        mac_op.sub = 1'b1;
        mac_op.a   = MUL_A_W'(xb_r);
        mac_op.b   = MUL_B_W'(ya_r);
        state_nxt  = S_XP_W;
      end
      S_XP_W: begin
        state_nxt = S_XP_ACC;
      end
      S_XP_ACC: begin
        if (seg_sub_r) begin
          cross_nxt = cross_r - acc[CROSS_W-1:0];
        end else begin
          cross_nxt = cross_r + acc[CROSS_W-1:0];
        end
        state_nxt = S_ROOT;
      end
      S_ROOT: begin
        if (!sqrt_busy) begin
          if (seg_sub_r) begin
            len_sum_nxt = len_sum_r - LEN_W'(sqrt_root);
          end else begin
            len_sum_nxt = len_sum_r + LEN_W'(sqrt_root);
          end
          state_nxt = S_FIN;
        end
      end

      // Scaled path length
      S_FIN: begin
        if (count_r >= CNT_W'(2)) begin
          opnd_nxt  = OPND_W'(len_sum_r);
          nch_nxt   = MAC_K_W'(NL);
          k_nxt     = '0;
          step_nxt  = MS_LEN;
          state_nxt = S_MS;
        end else begin
          plen_nxt  = '0;
          state_nxt = S_AREA;
        end
      end

      // Closing edge needs the first and last vertex
      S_AREA: begin
        if (count_r >= CNT_W'(3)) begin
          addr_a_nxt = '0;
          addr_b_nxt = AW'(count_r - CNT_W'(1));
          close_nxt  = 1'b1;
          state_nxt  = S_RD_A;
        end else begin
          area_nxt  = '0;
          state_nxt = S_DONE;
        end
      end

      // Closing cross term
      S_CL_0: begin
        mac_op.en  = 1'b1;
        mac_op.clr = 1'b1;
        mac_op.a   = MUL_A_W'(xb_r);
        mac_op.b   = MUL_B_W'(ya_r);
        state_nxt  = S_CL_1;
      end
      S_CL_1: begin
        mac_op.en  = 1'b1;
        mac_op.sub = 1'b1;
        mac_op.a   = MUL_A_W'(xa_r);
        mac_op.b   = MUL_B_W'(yb_r);
        state_nxt  = S_CL_W;
      end
      S_CL_W: begin
        state_nxt = S_CL_ACC;
      end
      S_CL_ACC: begin
        opnd_nxt  = OPND_W'(mag);
        nch_nxt   = MAC_K_W'(N1);
        k_nxt     = '0;
        step_nxt  = MS_AREA1;
        state_nxt = S_MS;
      end

      // Wide operand times scale, one 32-bit chunk a cycle
      S_MS: begin
        mac_op.en  = 1'b1;
        mac_op.clr = (k_r == '0);
        mac_op.k   = k_r;
        mac_op.a   = MUL_A_W'(opnd_r[k_r * CHUNK_W +: CHUNK_W]);
        mac_op.b   = MUL_B_W'(scale_r);
        k_nxt      = k_r + MAC_K_W'(1);
        if (k_r == MAC_K_W'(nch_r - MAC_K_W'(1))) begin
          state_nxt = S_MS_W;
        end
      end
      S_MS_W: begin
        state_nxt = S_MS_ACC;
      end
      S_MS_ACC: begin
        case (step_r)
          MS_LEN: begin
            if (|acc[ACC_W-1:PLEN_TOP]) begin
              plen_nxt = '1;
            end else begin
              plen_nxt = acc[PLEN_TOP-1:PLEN_SHIFT];
            end
            state_nxt = S_AREA;
          end
          MS_AREA1: begin
            opnd_nxt  = OPND_W'(acc[P1_W-1:0]);
            nch_nxt   = MAC_K_W'(N2);
            k_nxt     = '0;
            step_nxt  = MS_AREA2;
            state_nxt = S_MS;
          end
          MS_AREA2: begin
            if (|acc[ACC_W-1:AREA_TOP]) begin
              area_nxt = '1;
            end else begin
              area_nxt = acc[AREA_TOP-1:AREA_SHIFT];
            end
            state_nxt = S_DONE;
          end
          default: begin
            state_nxt = S_DONE;
          end
        endcase
      end

      // Hand the result to the output register once it is free
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          out_count_nxt  = count_r;
          out_plen_nxt   = plen_r;
          out_area_nxt   = area_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Register writes; a mode write clears the stack
    if (cfg_write) begin
      if (paddr[REG_SEL_BIT] == REG_MODE) begin
        mode_nxt    = pwdata[plpa_pkg::MODE_W-1:0];
        count_nxt   = '0;
        len_sum_nxt = '0;
        cross_nxt   = '0;
      end else if (pwdata[SCALE_W-1:0] != '0) begin
        scale_nxt = pwdata[SCALE_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mode_r      <= MODE_NONE;
      scale_r     <= plpa_pkg::SCALE_RESET;
      count_r     <= '0;
      len_sum_r   <= '0;
      cross_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mode_r      <= mode_nxt;
      scale_r     <= scale_nxt;
      count_r     <= count_nxt;
      len_sum_r   <= len_sum_nxt;
      cross_r     <= cross_nxt;
      out_valid_r <= out_valid_nxt;
    end
    step_r       <= step_nxt;
    close_r      <= close_nxt;
    seg_sub_r    <= seg_sub_nxt;
    addr_a_r     <= addr_a_nxt;
    addr_b_r     <= addr_b_nxt;
    xa_r         <= xa_nxt;
    ya_r         <= ya_nxt;
    xb_r         <= xb_nxt;
    yb_r         <= yb_nxt;
    opnd_r       <= opnd_nxt;
    k_r          <= k_nxt;
    nch_r        <= nch_nxt;
    status_r     <= status_nxt;
    plen_r       <= plen_nxt;
    area_r       <= area_nxt;
    out_status_r <= out_status_nxt;
    out_count_r  <= out_count_nxt;
    out_plen_r   <= out_plen_nxt;
    out_area_r   <= out_area_nxt;
  end

  assign in_stall         = (state_r != S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_vertex_count = out_count_r;
  assign out_path_length  = out_plen_r;
  assign out_polygon_area = out_area_r;

  // Register readback
  assign prdata = (paddr[REG_SEL_BIT] == REG_MODE) ?
                  plpa_pkg::APB_DATA_W'(mode_r) : plpa_pkg::APB_DATA_W'(scale_r);
  assign pready = 1'b1;

endmodule
